// ===== sv/sound_ram_transfer_control_assert.svh =====
// assertion macros for the sound ram transfer control checker
// needs clock and reset in scope at the point of use
`ifndef SOUND_RAM_TRANSFER_CONTROL_ASSERT_SVH
`define SOUND_RAM_TRANSFER_CONTROL_ASSERT_SVH

// same-cycle implication
`define SRTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/srtc_pkg.sv =====
// shared types and constants for the sound ram transfer control block
// no dependencies
package srtc_pkg;

   localparam int RAM_WORDS   = 262144;
   localparam int QUEUE_DEPTH = 32;

   localparam int PTR_W = $clog2(RAM_WORDS);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // address register write: pointer = value * 8 bytes / 2 = value * 4 halfwords
   localparam int PTR_SHIFT = 2;
   localparam int SRC_W     = 16 + PTR_SHIFT;
   // restoring reduction modulo RAM_WORDS, one step per cycle
   localparam int NSTEP     = SRC_W - PTR_W + 1;
   localparam int MOD_W     = SRC_W + 1;
   localparam int STEP_W    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam logic [MOD_W-1:0] DIV_INIT = MOD_W'(RAM_WORDS * (2 ** (NSTEP - 1)));

   // control area: halfword index 208..223
   localparam logic [4:0] CTL_PAGE = 5'd13;

   localparam logic [7:0] OFF_IRQ_ADDR = 8'hA4;
   localparam logic [7:0] OFF_START    = 8'hA6;
   localparam logic [7:0] OFF_FIFO     = 8'hA8;
   localparam logic [7:0] OFF_CTRL     = 8'hAA;
   localparam logic [7:0] OFF_TYPE     = 8'hAC;
   localparam logic [7:0] OFF_STATUS   = 8'hAE;

   localparam int ST_BUSY   = 10;
   localparam int ST_RDREQ  = 9;
   localparam int ST_WRREQ  = 8;
   localparam int ST_RWREQ  = 7;
   localparam int ST_IRQ    = 6;
   localparam int CT_ENABLE = 15;
   localparam int CT_IRQEN  = 6;
   localparam int CT_RW     = 5;
   localparam int CT_MODE   = 4;

   localparam logic [1:0] MODE_STOP      = 2'd0;
   localparam logic [1:0] MODE_MANUAL    = 2'd1;
   localparam logic [1:0] MODE_DMA_WRITE = 2'd2;
   localparam logic [1:0] MODE_DMA_READ  = 2'd3;

   typedef enum logic [2:0] {
      FN_REG_WRITE  = 3'd0,
      FN_REG_READ   = 3'd1,
      FN_DMA_IN     = 3'd2,
      FN_DMA_OUT    = 3'd3,
      FN_DMA_START  = 3'd4,
      FN_DMA_FINISH = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_MOD,
      S_DRAIN,
      S_LOAD
   } state_type;

endpackage

// ===== sv/srtc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module srtc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/sound_ram_transfer_control.sv =====
// top level of the sound ram transfer control block
// uses srtc_pkg and srtc_ram
//
// channel   direction  ports                                         handshake
// request   in         req_func, req_reg_index, req_write_data       start && !busy
// response  out        rsp_read_data, rsp_irq_raise,                 rsp_valid, one cycle
//                      rsp_queue_overflow, rsp_dma_write_request,
//                      rsp_dma_read_request
//
// a beat is taken at an edge with start high and busy low; its response is strobed after
// exec for register and dma-in beats, exec and load for dma-out (ram read latency), exec
// and the modulo steps for an address write (one modulo step per cycle in the shared
// subtractor) and exec and drain for a manual-mode control write (one fifo word into ram
// per cycle). after reset the ram is swept to zero, one word a cycle, with busy high.
// responses cannot be held off; the next beat is taken once the response is showing.
module sound_ram_transfer_control
   import srtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [8:0]  req_reg_index,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq_raise,
   output logic        rsp_queue_overflow,
   output logic        rsp_dma_write_request,
   output logic        rsp_dma_read_request
);

   // sequencer
   state_type         state_ff, state_in;

   // captured beat
   func_type          func_ff, func_in;
   logic [8:0]        idx_ff, idx_in;
   logic [15:0]       data_ff, data_in;

   // pointer, clearing sweep, fifo
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  drain_ff, drain_in;
   logic [15:0]       fifo_ff [QUEUE_DEPTH];
   logic              fifo_we;

   // shared modulo unit
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [MOD_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MOD_W-1:0]  mod_diff;

   // register file
   logic [15:0]       irq_addr_ff, irq_addr_in;
   logic [15:0]       xfer_start_ff, xfer_start_in;
   logic [15:0]       ctrl_ff, ctrl_in;
   logic [15:0]       xfer_type_ff, xfer_type_in;
   logic [15:0]       status_ff, status_in;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_rd_ff, rsp_rd_in;
   logic              rsp_irq_ff, rsp_irq_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // ram port
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [15:0]       ram_wdata;
   logic [15:0]       ram_rdata;

   // pointer step with wrap
   logic [PTR_W:0]    ptr_inc;
   logic [PTR_W-1:0]  ptr_adv;

   // register decode
   logic [7:0]        off;
   logic              ctl;
   logic [1:0]        mode;

   assign ptr_inc  = {1'b0, ptr_ff} + 1'b1;
   assign ptr_adv  = (ptr_inc == (PTR_W + 1)'(RAM_WORDS)) ? '0 : ptr_inc[PTR_W-1:0];
   assign off      = {idx_ff[6:0], 1'b0};
   assign ctl      = (idx_ff[8:4] == CTL_PAGE);
   assign mode     = data_ff[CT_MODE+1:CT_MODE];
   // one restoring step: subtract the shifted modulus when it fits
   assign mod_diff = (rem_ff >= div_ff) ? (rem_ff - div_ff) : rem_ff;

   srtc_ram #(
      .DEPTH (RAM_WORDS),
      .WIDTH (16)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      data_in       = data_ff;
      ptr_in        = ptr_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      drain_in      = drain_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      step_in       = step_ff;
      irq_addr_in   = irq_addr_ff;
      xfer_start_in = xfer_start_ff;
      ctrl_in       = ctrl_ff;
      xfer_type_in  = xfer_type_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_rd_in     = '0;
      rsp_irq_in    = 1'b0;
      rsp_ovf_in    = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = data_ff;
      fifo_we       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // zero sweep of the sample ram after reset
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == PTR_W'(RAM_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               func_in  = func_type'(req_func);
               idx_in   = req_reg_index;
               data_in  = req_write_data;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            // most beats finish here; the longer ones clear the strobe and move on
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (func_ff)
               FN_REG_WRITE: begin
                  if (ctl) begin
                     unique case (off)
                        OFF_IRQ_ADDR: irq_addr_in = data_ff;
                        OFF_START: begin
                           xfer_start_in = data_ff;
                           rem_in        = MOD_W'({data_ff, {PTR_SHIFT{1'b0}}});
                           div_in        = DIV_INIT;
                           step_in       = STEP_W'(NSTEP - 1);
                           state_in      = S_MOD;
                           rsp_valid_in  = 1'b0;
                        end
                        OFF_FIFO: begin
                           if (cnt_ff < CNT_W'(QUEUE_DEPTH)) begin
                              fifo_we = 1'b1;
                              cnt_in  = cnt_ff + 1'b1;
                           end else begin
                              rsp_ovf_in = 1'b1;
                           end
                        end
                        OFF_CTRL: begin
                           ctrl_in = data_ff;
                           // irq acknowledge when irq enable is cleared
                           if (status_ff[ST_IRQ] && !data_ff[CT_IRQEN]) begin
                              status_in[ST_IRQ] = 1'b0;
                           end
                           status_in[ST_RWREQ] = data_ff[CT_RW];
                           status_in[5:0]      = data_ff[5:0];
                           status_in[ST_BUSY]  = 1'b0;
                           unique case (mode) inside
                              MODE_STOP, MODE_MANUAL: begin
                                 status_in[ST_RDREQ] = 1'b0;
                                 status_in[ST_WRREQ] = 1'b0;
                              end
                              MODE_DMA_WRITE: begin
                                 status_in[ST_RDREQ] = 1'b0;
                                 status_in[ST_WRREQ] = 1'b1;
                              end
                              default: begin
                                 status_in[ST_RDREQ] = 1'b1;
                                 status_in[ST_WRREQ] = 1'b0;
                              end
                           endcase
                           if ((mode == MODE_MANUAL) && (cnt_ff != '0)) begin
                              drain_in     = '0;
                              state_in     = S_DRAIN;
                              rsp_valid_in = 1'b0;
                           end
                        end
                        OFF_TYPE: xfer_type_in = data_ff;
                        default: ;
                     endcase
                  end
               end
               FN_REG_READ: begin
                  if (ctl) begin
                     unique case (off)
                        OFF_IRQ_ADDR: rsp_rd_in = irq_addr_ff;
                        OFF_START:    rsp_rd_in = xfer_start_ff;
                        OFF_CTRL:     rsp_rd_in = ctrl_ff;
                        OFF_TYPE:     rsp_rd_in = xfer_type_ff;
                        OFF_STATUS:   rsp_rd_in = status_ff;
                        default:      rsp_rd_in = '0;
                     endcase
                  end
               end
               FN_DMA_IN: begin
                  ram_we = 1'b1;
                  ptr_in = ptr_adv;
               end
               FN_DMA_OUT: begin
                  // ram read issued at the old pointer, data lands next cycle
                  ptr_in       = ptr_adv;
                  state_in     = S_LOAD;
                  rsp_valid_in = 1'b0;
               end
               FN_DMA_START: status_in[ST_BUSY] = 1'b1;
               FN_DMA_FINISH: begin
                  status_in[ST_BUSY] = 1'b0;
                  if (ctrl_ff[CT_ENABLE] && ctrl_ff[CT_IRQEN]) begin
                     status_in[ST_IRQ] = 1'b1;
                     rsp_irq_in        = 1'b1;
                  end
               end
               default: ;
            endcase
         end

         S_MOD: begin
            rem_in  = mod_diff;
            div_in  = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               ptr_in       = mod_diff[PTR_W-1:0];
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         S_DRAIN: begin
            // one fifo word into ram per cycle, in order
            ram_we    = 1'b1;
            ram_wdata = fifo_ff[drain_ff];
            ptr_in    = ptr_adv;
            drain_in  = drain_ff + 1'b1;
            if ((CNT_W'(drain_ff) + 1'b1) == cnt_ff) begin
               cnt_in       = '0;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         S_LOAD: begin
            rsp_rd_in    = ram_rdata;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         irq_addr_ff   <= '0;
         xfer_start_ff <= '0;
         ctrl_ff       <= '0;
         xfer_type_ff  <= '0;
         status_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_rd_ff     <= '0;
         rsp_irq_ff    <= 1'b0;
         rsp_ovf_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         irq_addr_ff   <= irq_addr_in;
         xfer_start_ff <= xfer_start_in;
         ctrl_ff       <= ctrl_in;
         xfer_type_ff  <= xfer_type_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_rd_ff     <= rsp_rd_in;
         rsp_irq_ff    <= rsp_irq_in;
         rsp_ovf_ff    <= rsp_ovf_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      idx_ff   <= idx_in;
      data_ff  <= data_in;
      drain_ff <= drain_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      if (fifo_we) begin
         fifo_ff[cnt_ff[IDX_W-1:0]] <= data_ff;
      end
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_rd_ff;
   assign rsp_irq_raise         = rsp_irq_ff;
   assign rsp_queue_overflow    = rsp_ovf_ff;
   // status is settled while the response shows
   assign rsp_dma_write_request = status_ff[ST_WRREQ];
   assign rsp_dma_read_request  = status_ff[ST_RDREQ];

endmodule

// ===== sv/srtc_checker.sv =====
// port-level checker for the sound ram transfer control block, with its bind
// uses sound_ram_transfer_control_assert.svh
`include "sound_ram_transfer_control_assert.svh"

module srtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_read_data,
   input logic        rsp_irq_raise,
   input logic        rsp_queue_overflow
);

   // an accepted beat keeps the block busy in the next cycle
   `SRTC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted beat")
   // responses are single-cycle strobes with a gap
   `SRTC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "back to back response strobes")
   // a response only shows while the block is idle
   `SRTC_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "response while busy")
   // flags only on a response beat
   `SRTC_ASSERT_SAME(a_flags_quiet, !rsp_valid, !rsp_irq_raise && !rsp_queue_overflow,
                     "flag without response")
   // irq only comes from dma finish, which returns no data
   `SRTC_ASSERT_SAME(a_irq_no_data, rsp_irq_raise, rsp_read_data == 16'd0,
                     "irq response with read data")

endmodule

bind sound_ram_transfer_control srtc_checker u_srtc_checker (.*);
